// ===== rtl/core/fps_pkg.sv =====
package fps_pkg;

    // Operation codes carried in the input item
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_CANCEL  = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Pattern codes for a start item (codes above PAT_LAST_VALID are invalid)
    localparam logic [2:0] PAT_ACCEPTED = 3'd0;
    localparam logic [2:0] PAT_DUPLICATE = 3'd1;
    localparam logic [2:0] PAT_UNKNOWN = 3'd2;
    localparam logic [2:0] PAT_LOW_BATT = 3'd3;
    localparam logic [2:0] PAT_LAST_VALID = 3'd3;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_ACCEPT_VIB = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ACCEPT_LED = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DUP_PULSE = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DUP_GAP = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REJECT_VIB = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_MS = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_COUNT = 3'd6;

    localparam int unsigned MsW = 16;
    localparam int unsigned CountW = 7;
    localparam int unsigned IdxW = 8;

    // Input item
    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] pattern;
    } fps_in_t;

    // Result item
    typedef struct packed {
        logic           green_on;
        logic           red_on;
        logic           vibrate_on;
        logic [MsW-1:0] duration_ms;
        logic           busy_res;
    } fps_out_t;

    // Output drives
    typedef struct packed {
        logic vib;
        logic red;
        logic green;
    } drive_t;

    // Current register values
    typedef struct packed {
        logic [MsW-1:0]    accept_vib_ms;
        logic [MsW-1:0]    accept_led_ms;
        logic [MsW-1:0]    dup_pulse_ms;
        logic [MsW-1:0]    dup_gap_ms;
        logic [MsW-1:0]    reject_vib_ms;
        logic [MsW-1:0]    blink_ms;
        logic [CountW-1:0] blink_count;
    } cfg_regs_t;

    // One decoded step
    typedef struct packed {
        drive_t         drv;
        logic [MsW-1:0] ms;
    } step_t;

endpackage

// ===== rtl/core/feedback_pattern_sequencer.sv =====
// Channel  Direction  Ports                        Payload
// input    in         s_valid s_ready s_data       fps_in_t (operation, pattern)
// result   out        m_valid m_ready m_data       fps_out_t (drives, duration, busy)
// config   in         cfg_valid cfg_ready          cfg_index, cfg_data
//
// One item per cycle sustained while the result side accepts; an item passes through the input
// register, then decode and state update into the result register, where its result is offered.
// Reset (aresetn low, synchronous) empties both registers, stops any pattern and
// loads the default register values. A stalled result holds the result register and,
// once the input register is also full, drops s_ready. cfg_ready is always high.
module feedback_pattern_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fps_pkg::fps_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fps_pkg::fps_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fps_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [fps_pkg::MsW-1:0]       cfg_data
);
    import fps_pkg::*;

    logic      in_valid_reg, in_valid_next;
    fps_in_t   in_item_reg;
    logic      out_valid_reg, out_valid_next;
    fps_out_t  out_item_reg;
    logic      fire;
    fps_out_t  res;
    cfg_regs_t cfg;

    assign cfg_ready = 1'b1;

    fps_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Item moves from the input register into the result register
    assign fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    fps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Valid flags for both stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (fire) begin
            out_item_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_item_reg;

endmodule

// ===== rtl/core/fps_cfg.sv =====
module fps_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [fps_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [fps_pkg::MsW-1:0]       wr_data,
    output fps_pkg::cfg_regs_t            cfg
);
    import fps_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // Register write decode; indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_ACCEPT_VIB:  cfg_next.accept_vib_ms = wr_data;
                CFG_ACCEPT_LED:  cfg_next.accept_led_ms = wr_data;
                CFG_DUP_PULSE:   cfg_next.dup_pulse_ms = wr_data;
                CFG_DUP_GAP:     cfg_next.dup_gap_ms = wr_data;
                CFG_REJECT_VIB:  cfg_next.reject_vib_ms = wr_data;
                CFG_BLINK_MS:    cfg_next.blink_ms = wr_data;
                CFG_BLINK_COUNT: cfg_next.blink_count = wr_data[CountW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accept_vib_ms <= 16'd150;
            cfg_reg.accept_led_ms <= 16'd1000;
            cfg_reg.dup_pulse_ms <= 16'd100;
            cfg_reg.dup_gap_ms <= 16'd100;
            cfg_reg.reject_vib_ms <= 16'd500;
            cfg_reg.blink_ms <= 16'd200;
            cfg_reg.blink_count <= 7'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/fps_step.sv =====
module fps_step (
    input  logic [1:0]                 pat,
    input  logic [fps_pkg::IdxW-1:0]   idx,
    input  fps_pkg::cfg_regs_t         cfg,
    output fps_pkg::step_t             step
);
    import fps_pkg::*;

    logic [MsW-1:0]  green_rest;
    logic [IdxW-1:0] blink_steps;

    // Green-only remainder clamps at zero
    assign green_rest = (cfg.accept_led_ms > cfg.accept_vib_ms) ?
                        (cfg.accept_led_ms - cfg.accept_vib_ms) : '0;
    assign blink_steps = {cfg.blink_count, 1'b0};

    // Step table per pattern; anything past the list is the terminator
    always_comb begin
        step = '0;
        case ({1'b0, pat})
            PAT_ACCEPTED: begin
                if (idx == 8'd0) begin
                    step.drv.green = 1'b1;
                    step.drv.vib = 1'b1;
                    step.ms = cfg.accept_vib_ms;
                end else if (idx == 8'd1) begin
                    step.drv.green = 1'b1;
                    step.ms = green_rest;
                end
            end
            PAT_DUPLICATE: begin
                if (idx == 8'd0 || idx == 8'd2) begin
                    step.drv.vib = 1'b1;
                    step.ms = cfg.dup_pulse_ms;
                end else if (idx == 8'd1) begin
                    step.ms = cfg.dup_gap_ms;
                end
            end
            PAT_UNKNOWN: begin
                if (idx == 8'd0) begin
                    step.drv.red = 1'b1;
                    step.drv.vib = 1'b1;
                    step.ms = cfg.reject_vib_ms;
                end
            end
            PAT_LOW_BATT: begin
                if (idx < blink_steps) begin
                    step.drv.red = ~idx[0];
                    step.ms = cfg.blink_ms;
                end
            end
            default: step = '0;
        endcase
    end

endmodule

// ===== rtl/core/fps_ctrl.sv =====
module fps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  fps_pkg::fps_in_t    item,
    input  fps_pkg::cfg_regs_t  cfg,
    output fps_pkg::fps_out_t   res
);
    import fps_pkg::*;

    logic [1:0]      sel_reg, sel_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            play_reg, play_next;
    drive_t          drv_reg, drv_next;

    logic [IdxW:0]   next_idx;
    logic [IdxW:0]   count;
    logic [1:0]      dec_pat;
    logic [IdxW-1:0] dec_idx;
    step_t           step;
    logic [MsW-1:0]  ms;
    op_t             op;

    assign op = op_t'(item.operation);
    assign next_idx = {1'b0, idx_reg} + 9'd1;

    // Number of steps in the running pattern, terminator included
    always_comb begin
        case ({1'b0, sel_reg})
            PAT_ACCEPTED:  count = 9'd3;
            PAT_DUPLICATE: count = 9'd4;
            PAT_UNKNOWN:   count = 9'd2;
            default:       count = {1'b0, cfg.blink_count, 1'b1};
        endcase
    end

    // Step being entered: step 0 of the new pattern, or the next one
    assign dec_pat = (op == OP_START) ? item.pattern[1:0] : sel_reg;
    assign dec_idx = (op == OP_START) ? '0 : next_idx[IdxW-1:0];

    fps_step u_step (
        .pat  (dec_pat),
        .idx  (dec_idx),
        .cfg  (cfg),
        .step (step)
    );

    // Next state; a zero-length step ends the pattern
    always_comb begin
        sel_next = sel_reg;
        idx_next = idx_reg;
        play_next = play_reg;
        drv_next = drv_reg;
        ms = '0;
        case (op)
            OP_START: begin
                if (item.pattern > PAT_LAST_VALID) begin
                    idx_next = '0;
                    play_next = 1'b0;
                    drv_next = '0;
                end else begin
                    sel_next = item.pattern[1:0];
                    idx_next = '0;
                    play_next = 1'b1;
                    drv_next = step.drv;
                    ms = step.ms;
                end
            end
            OP_ADVANCE: begin
                if (play_reg) begin
                    if (next_idx >= count) begin
                        idx_next = '0;
                        play_next = 1'b0;
                        drv_next = '0;
                    end else begin
                        idx_next = next_idx[IdxW-1:0];
                        drv_next = step.drv;
                        ms = step.ms;
                    end
                end
            end
            OP_CANCEL: begin
                idx_next = '0;
                play_next = 1'b0;
                drv_next = '0;
            end
            default: ms = '0;
        endcase
        if ((op == OP_START || op == OP_ADVANCE) && play_next && ms == '0) begin
            idx_next = '0;
            play_next = 1'b0;
            drv_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
            idx_reg <= '0;
            play_reg <= 1'b0;
            drv_reg <= '0;
        end else if (fire) begin
            sel_reg <= sel_next;
            idx_reg <= idx_next;
            play_reg <= play_next;
            drv_reg <= drv_next;
        end
    end

    // Result reflects the state after this item
    assign res.green_on = drv_next.green;
    assign res.red_on = drv_next.red;
    assign res.vibrate_on = drv_next.vib;
    assign res.duration_ms = ms;
    assign res.busy_res = play_next;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import fps_pkg::*;

    // Idle cycles with no transfer on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 200;
    // Index past the register list, the block ignores writes to it
    localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

    localparam cfg_regs_t RESET_REGS = '{
        accept_vib_ms: 16'd150, accept_led_ms: 16'd1000, dup_pulse_ms: 16'd100,
        dup_gap_ms: 16'd100, reject_vib_ms: 16'd500, blink_ms: 16'd200, blink_count: 7'd3
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    fps_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b1;
    fps_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [MsW-1:0]      cfg_data  = '0;

    // Predicted sequencer state and register copy
    cfg_regs_t   regs        = RESET_REGS;
    logic [1:0]  cur_pattern = '0;
    logic [7:0]  cur_step    = '0;
    logic        playing     = 1'b0;
    drive_t      cur_drive   = '0;

    fps_out_t    pending_results[$];
    int          mismatches   = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          settings     = 0;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    bit          idle_on      = 1'b1;

    feedback_pattern_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Pattern predictor
    // ------------------------------------------------------------------

    // Number of steps including the terminator
    function automatic int step_total(input logic [1:0] pat);
        case ({1'b0, pat})
            PAT_ACCEPTED:  return 3;
            PAT_DUPLICATE: return 4;
            PAT_UNKNOWN:   return 2;
            default:       return 2 * int'(regs.blink_count) + 1;
        endcase
    endfunction

    // Drives and duration of one step, from the registers as they are now
    function automatic step_t pattern_step(input logic [1:0] pat, input logic [7:0] idx);
        step_t st;
        st = '0;
        case ({1'b0, pat})
            PAT_ACCEPTED: begin
                if (idx == 8'd0) begin
                    st.drv.green = 1'b1;
                    st.drv.vib   = 1'b1;
                    st.ms        = regs.accept_vib_ms;
                end else if (idx == 8'd1) begin
                    st.drv.green = 1'b1;
                    // remainder of the green dwell, clamped at zero
                    st.ms = (regs.accept_led_ms > regs.accept_vib_ms) ?
                            regs.accept_led_ms - regs.accept_vib_ms : '0;
                end
            end
            PAT_DUPLICATE: begin
                if (idx == 8'd0 || idx == 8'd2) begin
                    st.drv.vib = 1'b1;
                    st.ms      = regs.dup_pulse_ms;
                end else if (idx == 8'd1) begin
                    st.ms = regs.dup_gap_ms;
                end
            end
            PAT_UNKNOWN: begin
                if (idx == 8'd0) begin
                    st.drv.red = 1'b1;
                    st.drv.vib = 1'b1;
                    st.ms      = regs.reject_vib_ms;
                end
            end
            default: begin
                // low battery: red on even steps, off on odd ones
                if (int'(idx) < 2 * int'(regs.blink_count)) begin
                    st.drv.red = ~idx[0];
                    st.ms      = regs.blink_ms;
                end
            end
        endcase
        return st;
    endfunction

    function automatic void stop_pattern();
        playing   = 1'b0;
        cur_step  = '0;
        cur_drive = '0;
    endfunction

    // Enters cur_step; a zero duration ends the pattern
    function automatic logic [MsW-1:0] enter_step();
        step_t st;
        st = pattern_step(cur_pattern, cur_step);
        cur_drive = st.drv;
        if (st.ms == '0) stop_pattern();
        return st.ms;
    endfunction

    function automatic fps_out_t predict_feedback(input fps_in_t item);
        fps_out_t       res;
        logic [MsW-1:0] ms;
        int             nxt;
        ms = '0;
        case (op_t'(item.operation))
            OP_START: begin
                if (item.pattern > PAT_LAST_VALID) begin
                    stop_pattern();
                end else begin
                    cur_pattern = item.pattern[1:0];
                    cur_step    = '0;
                    playing     = 1'b1;
                    ms          = enter_step();
                end
            end
            OP_ADVANCE: begin
                if (playing) begin
                    nxt = int'(cur_step) + 1;
                    if (nxt >= step_total(cur_pattern) || nxt > 255) begin
                        stop_pattern();
                    end else begin
                        cur_step = nxt[7:0];
                        ms       = enter_step();
                    end
                end
            end
            OP_CANCEL: stop_pattern();
            OP_QUERY: ;   // status only
        endcase
        res.green_on    = cur_drive.green;
        res.red_on      = cur_drive.red;
        res.vibrate_on  = cur_drive.vib;
        res.duration_ms = ms;
        res.busy_res    = playing;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // One input transfer; valid is only lowered at the start of a gap
    task automatic send_item(input fps_in_t item);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_feedback(item));
        items_sent++;
    endtask

    // Hold the input off until every predicted result has been seen
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ACCEPT_VIB:  regs.accept_vib_ms = val;
            CFG_ACCEPT_LED:  regs.accept_led_ms = val;
            CFG_DUP_PULSE:   regs.dup_pulse_ms  = val;
            CFG_DUP_GAP:     regs.dup_gap_ms    = val;
            CFG_REJECT_VIB:  regs.reject_vib_ms = val;
            CFG_BLINK_MS:    regs.blink_ms      = val;
            CFG_BLINK_COUNT: regs.blink_count   = val[CountW-1:0];
            default: ;
        endcase
    endtask

    // Full register load while the pipeline is empty; a pattern may still be playing
    task automatic load_regs(input cfg_regs_t r);
        drain();
        write_reg(CFG_ACCEPT_VIB, r.accept_vib_ms);
        write_reg(CFG_ACCEPT_LED, r.accept_led_ms);
        write_reg(CFG_DUP_PULSE, r.dup_pulse_ms);
        write_reg(CFG_DUP_GAP, r.dup_gap_ms);
        write_reg(CFG_REJECT_VIB, r.reject_vib_ms);
        write_reg(CFG_BLINK_MS, r.blink_ms);
        // upper data bits are junk, only seven are kept
        write_reg(CFG_BLINK_COUNT, {9'($urandom_range(0, 511)), r.blink_count});
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [MsW-1:0] pick_ms();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, 1200));
        endcase
    endfunction

    function automatic cfg_regs_t random_regs();
        cfg_regs_t r;
        r.accept_vib_ms = pick_ms();
        r.accept_led_ms = pick_ms();
        r.dup_pulse_ms  = pick_ms();
        r.dup_gap_ms    = pick_ms();
        r.reject_vib_ms = pick_ms();
        r.blink_ms      = pick_ms();
        case ($urandom_range(0, 9))
            0:       r.blink_count = '0;
            1:       r.blink_count = '1;
            2:       r.blink_count = 7'($urandom);
            default: r.blink_count = 7'($urandom_range(1, 6));
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: back-pressure, checking, watchdog
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left > 0) stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
        m_ready <= (stall_left == 0);
    end

    task automatic check_field(input string label, input logic [MsW-1:0] want,
                               input logic [MsW-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        fps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
            end else begin
                want = pending_results.pop_front();
                check_field("green_on", 16'(want.green_on), 16'(m_data.green_on));
                check_field("red_on", 16'(want.red_on), 16'(m_data.red_on));
                check_field("vibrate_on", 16'(want.vibrate_on), 16'(m_data.vibrate_on));
                check_field("duration_ms", want.duration_ms, m_data.duration_ms);
                check_field("busy_res", 16'(want.busy_res), 16'(m_data.busy_res));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: accepted and duplicate through their end, restart and cancel
    task automatic test_reset_patterns();
        send_item(fps_in_t'{OP_START, PAT_ACCEPTED});
        repeat (3) send_item(fps_in_t'{OP_ADVANCE, 3'd0});   // last one while inactive
        send_item(fps_in_t'{OP_START, PAT_DUPLICATE});
        send_item(fps_in_t'{OP_ADVANCE, 3'd7});
        send_item(fps_in_t'{OP_QUERY, 3'd5});
        repeat (2) send_item(fps_in_t'{OP_ADVANCE, 3'd2});
        send_item(fps_in_t'{OP_START, PAT_UNKNOWN});
        send_item(fps_in_t'{OP_START, PAT_LOW_BATT});        // restart while playing
        send_item(fps_in_t'{OP_ADVANCE, 3'd1});
        send_item(fps_in_t'{OP_CANCEL, 3'd3});
    endtask

    // Start codes past the pattern list stop a running pattern
    task automatic test_invalid_starts();
        send_item(fps_in_t'{OP_START, PAT_DUPLICATE});
        for (int p = int'(PAT_LAST_VALID) + 1; p < 8; p++)
            send_item(fps_in_t'{OP_START, 3'(p)});
    endtask

    // Extreme registers: clamped remainder, zero blinks, zero gap and zero reject
    task automatic test_edge_regs();
        load_regs(cfg_regs_t'{accept_vib_ms: '1, accept_led_ms: '0, dup_pulse_ms: '1,
                              dup_gap_ms: '0, reject_vib_ms: '0, blink_ms: '1,
                              blink_count: '0});
        send_item(fps_in_t'{OP_START, PAT_ACCEPTED});
        send_item(fps_in_t'{OP_ADVANCE, 3'd4});
        send_item(fps_in_t'{OP_START, PAT_LOW_BATT});
        send_item(fps_in_t'{OP_START, PAT_DUPLICATE});
        send_item(fps_in_t'{OP_ADVANCE, 3'd6});
        send_item(fps_in_t'{OP_START, PAT_UNKNOWN});
    endtask

    // Longest low-battery pattern, walks the step index to its top
    task automatic test_long_blink();
        cfg_regs_t r;
        r = random_regs();
        r.blink_count = '1;
        r.blink_ms    = 16'($urandom_range(1, 65535));
        load_regs(r);
        send_item(fps_in_t'{OP_START, PAT_LOW_BATT});
        repeat (2 * int'(r.blink_count) + 2) send_item(fps_in_t'{OP_ADVANCE, 3'($urandom)});
    endtask

    // Mostly start-then-advance sequences, some noise and register changes
    task automatic test_random(input int target);
        int         stop_at;
        int         adv;
        logic [2:0] pat;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) load_regs(random_regs());
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) send_item(fps_in_t'(5'($urandom)));
            end else begin
                pat = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) :
                                                     3'($urandom_range(0, 3));
                send_item(fps_in_t'{OP_START, pat});
                adv = $urandom_range(0, step_total(pat[1:0]) + 1);
                if (adv > 14) adv = 14;
                for (int k = 0; k < adv; k++) begin
                    if ($urandom_range(0, 15) == 0) send_item(fps_in_t'{OP_QUERY, 3'($urandom)});
                    // new register values mid-pattern
                    if ($urandom_range(0, 30) == 0) load_regs(random_regs());
                    send_item(fps_in_t'{OP_ADVANCE, 3'($urandom)});
                end
                if ($urandom_range(0, 3) == 0) send_item(fps_in_t'{OP_CANCEL, 3'($urandom)});
            end
            if ($urandom_range(0, 40) == 0) drain();
        end
    endtask

    // Back-to-back transfers with no idling on either side
    task automatic test_full_rate();
        drain();
        idle_on = 1'b0;
        test_random(150);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_patterns();
        test_invalid_starts();
        test_edge_regs();
        test_long_blink();
        load_regs(RESET_REGS);
        test_random(620);
        test_full_rate();

        drain();
        repeat (4) @(posedge aclk);
        $display("Ran %0d items and checked %0d results over %0d register loads", items_sent,
                 results_seen, settings);
        $display("Covered all patterns, invalid starts, restarts, cancels and a full 127-blink run");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== feedback_pattern_sequencer.f =====
rtl/core/fps_pkg.sv
rtl/core/fps_cfg.sv
rtl/core/fps_step.sv
rtl/core/fps_ctrl.sv
rtl/core/feedback_pattern_sequencer.sv
tb/testbench.sv
